// ----- sv/totp_pkg.sv -----
// ----------------------------------------------------------------------------
// totp_pkg
// shared types, register indexes and constants of the totp code generator
// ----------------------------------------------------------------------------
package totp_pkg;

  localparam int unsigned MaxKeyBytes = 24;
  localparam int unsigned KeyWords    = 6;

  localparam int unsigned CfgAddrW = 3;
  localparam logic [CfgAddrW-1:0] CfgKeyUpper   = 3'd0;
  localparam logic [CfgAddrW-1:0] CfgKeyMiddle  = 3'd1;
  localparam logic [CfgAddrW-1:0] CfgKeyLower   = 3'd2;
  localparam logic [CfgAddrW-1:0] CfgKeyLength  = 3'd3;
  localparam logic [CfgAddrW-1:0] CfgPeriod     = 3'd4;
  localparam logic [CfgAddrW-1:0] CfgDigitCount = 3'd5;

  localparam logic [4:0]  KeyLengthRst   = 5'd20;
  localparam logic [15:0] PeriodRst      = 16'd30;
  localparam logic [3:0]  DigitCountRst  = 4'd6;

  localparam logic [31:0] IpadWord  = 32'h3636_3636;
  localparam logic [31:0] OpadWord  = 32'h5C5C_5C5C;
  localparam logic [31:0] PadMarker = 32'h8000_0000;
  localparam logic [31:0] InnerBits = 32'd576;
  localparam logic [31:0] OuterBits = 32'd672;
  localparam logic [31:0] TruncMask = 32'h7FFF_FFFF;

  localparam logic [159:0] Sha1Iv =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

  // start request to the hash engine
  typedef struct packed {
    logic start;
    logic init;   // begin a new message from the initial chaining value
  } sha_ctrl_t;

  // ten to the power of the digit count, count clamped to one..nine
  function automatic logic [29:0] pow10(input logic [3:0] digits);
    logic [29:0] m;
    case (digits)
      4'd0, 4'd1: m = 30'd10;
      4'd2:       m = 30'd100;
      4'd3:       m = 30'd1000;
      4'd4:       m = 30'd10000;
      4'd5:       m = 30'd100000;
      4'd6:       m = 30'd1000000;
      4'd7:       m = 30'd10000000;
      4'd8:       m = 30'd100000000;
      default:    m = 30'd1000000000;
    endcase
    return m;
  endfunction

endpackage

// ----- sv/totp_code_generator_unit.sv -----
// ----------------------------------------------------------------------------
// totp_code_generator_unit
// time based one-time code: counter = time / period, hmac-sha1, truncation
// ----------------------------------------------------------------------------
// steps per beat: bit-serial time divide, four sha-1 blocks, bit-serial
//   modulo, plus handoff to the output slot
// a new beat is taken only after the last one has moved to the output slot,
//   as the round engine and the one-bit-per-cycle divider are single and shared
// reset: rst_ni clears control, key regs to zero, key length 20,
//   period 30, digit count 6
module totp_code_generator_unit import totp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write port
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [63:0]         cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [63:0]         s_axis_tdata,   // unix_time
  // output stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [47:0]         m_axis_tdata    // code[29:0], remaining_seconds[45:30]
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDivT = 5'b00010,
    StHash = 5'b00100,
    StDivM = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // config registers
  logic [63:0] key_upper_q, key_middle_q, key_lower_q;
  logic [4:0]  key_length_q;
  logic [15:0] period_q;
  logic [3:0]  digit_count_q;

  // item payload
  logic [63:0]  ctr_q, ctr_d;
  logic [15:0]  rsec_q, rsec_d;
  logic [159:0] ihash_q, ihash_d;
  logic [29:0]  code_q, code_d;
  logic [1:0]   blk_q, blk_d;

  // output slot
  logic        out_valid_q, out_valid_d;
  logic [47:0] out_data_q, out_data_d;

  // submodule links
  logic        div_start;
  logic [63:0] div_dividend;
  logic [31:0] div_divisor;
  logic        div_done;
  logic [63:0] div_quo;
  logic [31:0] div_rem;
  sha_ctrl_t   sha_ctrl;
  logic [31:0] sha_word;
  logic [3:0]  sha_idx;
  logic        sha_done;
  logic [159:0] sha_digest;

  logic [15:0]  period_eff;
  logic [29:0]  modulus;
  logic [4:0]   klen;
  logic [191:0] key_all;
  logic [191:0] key_msk;
  logic [31:0]  key_word;
  logic [7:0]   tidx;
  logic [31:0]  trunc_word;
  logic         out_free;

  assign period_eff = (period_q == 16'd0) ? 16'd1 : period_q;
  assign modulus    = pow10(digit_count_q);
  assign klen       = (key_length_q > 5'(MaxKeyBytes)) ? 5'(MaxKeyBytes) : key_length_q;
  assign out_free   = !out_valid_q || m_axis_tready;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_upper_q   <= '0;
      key_middle_q  <= '0;
      key_lower_q   <= '0;
      key_length_q  <= KeyLengthRst;
      period_q      <= PeriodRst;
      digit_count_q <= DigitCountRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgKeyUpper:   key_upper_q   <= cfg_wdata_i;
        CfgKeyMiddle:  key_middle_q  <= cfg_wdata_i;
        CfgKeyLower:   key_lower_q   <= cfg_wdata_i;
        CfgKeyLength:  key_length_q  <= cfg_wdata_i[4:0];
        CfgPeriod:     period_q      <= cfg_wdata_i[15:0];
        CfgDigitCount: digit_count_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // key bytes past the used length read as zero
  always_comb begin
    key_all = {key_upper_q, key_middle_q, key_lower_q};
    for (int b = 0; b < MaxKeyBytes; b++) begin
      key_msk[191-8*b -: 8] = (5'(b) < klen) ? key_all[191-8*b -: 8] : 8'h00;
    end
  end

  // message word for the current block and round
  always_comb begin
    key_word = 32'h0;
    for (int i = 0; i < KeyWords; i++) begin
      if (sha_idx == 4'(i)) begin
        key_word = key_msk[191-32*i -: 32];
      end
    end
    sha_word = 32'h0;
    case (blk_q)
      2'd0: sha_word = key_word ^ IpadWord;
      2'd1: begin
        case (sha_idx)
          4'd0:    sha_word = ctr_q[63:32];
          4'd1:    sha_word = ctr_q[31:0];
          4'd2:    sha_word = PadMarker;
          4'd15:   sha_word = InnerBits;
          default: sha_word = 32'h0;
        endcase
      end
      2'd2: sha_word = key_word ^ OpadWord;
      default: begin
        case (sha_idx)
          4'd0:    sha_word = ihash_q[159:128];
          4'd1:    sha_word = ihash_q[127:96];
          4'd2:    sha_word = ihash_q[95:64];
          4'd3:    sha_word = ihash_q[63:32];
          4'd4:    sha_word = ihash_q[31:0];
          4'd5:    sha_word = PadMarker;
          4'd15:   sha_word = OuterBits;
          default: sha_word = 32'h0;
        endcase
      end
    endcase
  end

  // dynamic truncation: low nibble of the last digest byte picks the offset
  assign tidx       = 8'd159 - {1'b0, sha_digest[3:0], 3'b000};
  assign trunc_word = sha_digest[tidx -: 32] & TruncMask;

  // sequencer
  always_comb begin
    state_d      = state_q;
    ctr_d        = ctr_q;
    rsec_d       = rsec_q;
    ihash_d      = ihash_q;
    code_d       = code_q;
    blk_d        = blk_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_data_d   = out_data_q;
    div_start    = 1'b0;
    div_dividend = s_axis_tdata;
    div_divisor  = {16'h0, period_eff};
    sha_ctrl     = '0;
    unique case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          div_start = 1'b1;
          state_d   = StDivT;
        end
      end
      StDivT: begin
        if (div_done) begin
          ctr_d         = div_quo;
          rsec_d        = period_eff - div_rem[15:0];
          blk_d         = 2'd0;
          sha_ctrl.start = 1'b1;
          sha_ctrl.init  = 1'b1;
          state_d       = StHash;
        end
      end
      StHash: begin
        if (sha_done) begin
          if (blk_q == 2'd1) begin
            ihash_d = sha_digest;
          end
          if (blk_q == 2'd3) begin
            div_start    = 1'b1;
            div_dividend = {32'h0, trunc_word};
            div_divisor  = {2'b00, modulus};
            state_d      = StDivM;
          end else begin
            blk_d          = blk_q + 2'd1;
            sha_ctrl.start = 1'b1;
            sha_ctrl.init  = (blk_q == 2'd1);
          end
        end
      end
      StDivM: begin
        if (div_done) begin
          code_d  = div_rem[29:0];
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = {2'b00, rsec_q, code_q};
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      blk_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blk_q       <= blk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctr_q      <= ctr_d;
    rsec_q     <= rsec_d;
    ihash_q    <= ihash_d;
    code_q     <= code_d;
    out_data_q <= out_data_d;
  end

  totp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  totp_sha1 u_sha1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (sha_ctrl),
    .word_i     (sha_word),
    .word_idx_o (sha_idx),
    .done_o     (sha_done),
    .digest_o   (sha_digest)
  );

  // input taken only between items, result waits in its own slot
  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // hash engine only finishes while the sequencer waits on it
  a_sha_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sha_done |-> state_q == StHash)
    else $error("hash done outside hash phase");

  // divider only finishes in one of the two divide phases
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == StDivT || state_q == StDivM))
    else $error("divide done outside divide phase");

  // the code is below the modulus when it is captured
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDivM && div_done) |-> div_rem < {2'b00, modulus})
    else $error("code not below modulus");

  // remaining seconds never zero when a result is posted
  a_rsec_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free) |=> m_axis_tdata[45:30] != 16'd0)
    else $error("remaining seconds zero");

endmodule

// ----- sv/totp_div.sv -----
// ----------------------------------------------------------------------------
// totp_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module totp_div import totp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic [31:0] rem_o
);

  logic [63:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [32:0] trial;
  logic [32:0] diff;

  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = diff[31:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ----- sv/totp_sha1.sv -----
// ----------------------------------------------------------------------------
// totp_sha1
// sha-1 compression engine, one round per cycle, 16-word schedule window
// ----------------------------------------------------------------------------
module totp_sha1 import totp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  sha_ctrl_t    ctrl_i,
  input  logic [31:0]  word_i,    // message word for rounds 0 to 15
  output logic [3:0]   word_idx_o,
  output logic         done_o,
  output logic [159:0] digest_o
);

  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] a_d, b_d, c_d, d_d, e_d;
  logic [159:0] h_q, h_d;
  logic [31:0] w_q [16];
  logic [31:0] w_d [16];
  logic [6:0]  rnd_q, rnd_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] wt, wx, f, k, t;
  logic [159:0] hs;

  always_comb begin
    wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    wt = (rnd_q < 7'd16) ? word_i : {wx[30:0], wx[31]};
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A82_7999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9_EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1B_BCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62_C1D6;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + wt;
  end

  always_comb begin
    a_d = a_q; b_d = b_q; c_d = c_q; d_d = d_q; e_d = e_q;
    h_d    = h_q;
    rnd_d  = rnd_q;
    busy_d = busy_q;
    done_d = 1'b0;
    hs     = ctrl_i.init ? Sha1Iv : h_q;
    for (int i = 0; i < 16; i++) begin
      w_d[i] = w_q[i];
    end
    if (ctrl_i.start) begin
      h_d    = hs;
      a_d    = hs[159:128];
      b_d    = hs[127:96];
      c_d    = hs[95:64];
      d_d    = hs[63:32];
      e_d    = hs[31:0];
      rnd_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rnd_q == 7'd80) begin
        h_d = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
               h_q[63:32] + d_q, h_q[31:0] + e_q};
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        e_d = d_q;
        d_d = c_q;
        c_d = {b_q[1:0], b_q[31:2]};
        b_d = a_q;
        a_d = t;
        for (int i = 0; i < 15; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[15] = wt;
        rnd_d = rnd_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      rnd_q  <= rnd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d; c_q <= c_d; d_q <= d_d; e_q <= e_d;
    h_q <= h_d;
    for (int i = 0; i < 16; i++) begin
      w_q[i] <= w_d[i];
    end
  end

  assign word_idx_o = rnd_q[3:0];
  assign done_o     = done_q;
  assign digest_o   = h_q;

endmodule
